### rtl/core/sirt_pkg.sv
// ----------------------------------------------------------------------------
// sirt_pkg: shared types and constants
// Character codes, sequencer states and divider control words for the
// signed integer to radix text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sirt_pkg;

   localparam logic [6:0] CHAR_MINUS = 7'h2D;
   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_NINE  = 7'h39;
   localparam logic [6:0] CHAR_A     = 7'h41;
   localparam logic [6:0] CHAR_F     = 7'h46;

   localparam logic [4:0] RADIX_MIN   = 5'd2;
   localparam logic [4:0] RADIX_MAX   = 5'd16;
   localparam logic [4:0] RADIX_RESET = 5'd10;

   localparam int CHUNK_BITS = 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       start;
      logic [4:0] radix;
   } div_ctl_type;

   typedef struct packed {
      logic       done;
      logic [3:0] remainder;
   } div_stat_type;

   function automatic logic [6:0] digit_char(input logic [3:0] digit);
      logic [6:0] ch;
      if (digit < 4'd10) begin
         ch = CHAR_ZERO + {3'b000, digit};
      end else begin
         ch = CHAR_A + {3'b000, digit} - 7'd10;
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

### rtl/core/sirt_divider.sv
// ----------------------------------------------------------------------------
// sirt_divider: iterative divide by radix
// Divides an unsigned word by a radix of 2 to 16, eight dividend bits per
// cycle, giving quotient and remainder with a one-cycle done pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module sirt_divider #(
   parameter int PAD_BITS = 32
) (
   input  wire                        clock,
   input  wire                        reset,
   input  sirt_pkg::div_ctl_type      ctl,
   input  wire  [PAD_BITS-1:0]        dividend,
   output sirt_pkg::div_stat_type     stat,
   output logic [PAD_BITS-1:0]        quotient
);
   import sirt_pkg::*;

   localparam int DIV_STEPS = PAD_BITS / CHUNK_BITS;
   localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

   logic [PAD_BITS-1:0] work_ff, work_in;
   logic [3:0]          rem_ff, rem_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   always_comb begin
      logic [4:0]                   r;
      logic [CHUNK_BITS-1:0]        chunk;
      logic [CHUNK_BITS-1:0]        qbits;
      logic [PAD_BITS+CHUNK_BITS-1:0] shifted;
      r       = {1'b0, rem_ff};
      chunk   = work_ff[PAD_BITS-1 -: CHUNK_BITS];
      qbits   = '0;
      for (int j = CHUNK_BITS - 1; j >= 0; j--) begin
         r = {r[3:0], chunk[j]};
         if (r >= ctl.radix) begin
            r        = r - ctl.radix;
            qbits[j] = 1'b1;
         end
      end
      shifted = {work_ff, qbits};

      work_in = work_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         work_in = dividend;
         rem_in  = 4'd0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = shifted[PAD_BITS-1:0];
         rem_in  = r[3:0];
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.done      = done_ff;
   assign stat.remainder = rem_ff;
   assign quotient       = work_ff;

endmodule

`default_nettype wire

### rtl/core/signed_integer_to_radix_text.sv
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text: integer to radix text converter
// Converts one signed integer per word into ASCII text in radix 2 to 16,
// leading minus for negative values, most significant digit first.
//
//  channel  dir  handshake                  payload
//  req      in   req_tvalid / req_tready    req_tdata: value
//  rsp      out  rsp_tvalid / rsp_tready    rsp_tdata: text_char, rsp_tlast
//  csr      in   csr_we                     csr_wdata: radix
//
// Each digit comes from the shared divide-by-radix unit, which starts the
// next division as soon as the last one is done.
// A word is divided digit by digit; then a minus for a negative value and
// the digits are sent on rsp. Digits are stacked in a shift line and then
// emitted one per cycle while rsp is not stalled.
// Reset is synchronous and restores radix 10; rsp stalls hold the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_integer_to_radix_text #(
   parameter int VALUE_BITS = 32
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_tvalid,
   output logic                                   req_tready,
   input  wire  [((VALUE_BITS+7)/8)*8-1:0]        req_tdata,  // value
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   output logic [7:0]                             rsp_tdata,  // text_char, zero pad
   output logic                                   rsp_tlast,
   input  wire                                    csr_we,
   input  wire  [4:0]                             csr_wdata   // radix
);
   import sirt_pkg::*;

   localparam int PAD_BITS = ((VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS) * CHUNK_BITS;
   localparam int CNT_W    = $clog2(VALUE_BITS + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(VALUE_BITS - 1);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   state_type           state_ff, state_in;
   logic [4:0]          radix_ff;
   logic [4:0]          radix_eff;
   logic                neg_ff, neg_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [3:0]          digits_ff [VALUE_BITS];
   logic [3:0]          digits_in [VALUE_BITS];
   logic                out_valid_ff, out_valid_in;
   logic [6:0]          out_char_ff, out_char_in;
   logic                out_last_ff, out_last_in;

   logic [VALUE_BITS-1:0] in_value;
   logic [VALUE_BITS-1:0] in_mag;
   logic                  in_neg;
   logic [PAD_BITS-1:0]   dividend;
   logic [PAD_BITS-1:0]   quotient;
   div_ctl_type           div_ctl;
   div_stat_type          div_stat;
   logic                  out_free;
   logic                  accept;
   logic                  div_final;

   sirt_divider #(
      .PAD_BITS (PAD_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (dividend),
      .stat     (div_stat),
      .quotient (quotient)
   );

   always_comb begin
      if (radix_ff < RADIX_MIN) begin
         radix_eff = RADIX_MIN;
      end else if (radix_ff > RADIX_MAX) begin
         radix_eff = RADIX_MAX;
      end else begin
         radix_eff = radix_ff;
      end
   end

   assign in_value   = req_tdata[VALUE_BITS-1:0];
   assign in_neg     = in_value[VALUE_BITS-1];
   assign in_mag     = in_neg ? (~in_value + 1'b1) : in_value;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign div_final  = div_stat.done && ((quotient == '0) || (count_ff == CNT_FULL));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_final) begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free && (count_ff == CNT_ONE)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      neg_in       = neg_ff;
      count_in     = count_ff;
      digits_in    = digits_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      div_ctl.start = 1'b0;
      div_ctl.radix = radix_eff;
      dividend      = quotient;
      case (state_ff)
         ST_IDLE: begin
            dividend = PAD_BITS'(in_mag);
            if (accept) begin
               div_ctl.start = 1'b1;
               neg_in        = in_neg;
               count_in      = '0;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               digits_in[0] = div_stat.remainder;
               for (int i = 1; i < VALUE_BITS; i++) begin
                  digits_in[i] = digits_ff[i-1];
               end
               count_in = count_ff + 1'b1;
               if (!div_final) begin
                  div_ctl.start = 1'b1;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_MINUS;
               out_last_in  = 1'b0;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = digit_char(digits_ff[0]);
               out_last_in  = (count_ff == CNT_ONE);
               for (int i = 0; i < VALUE_BITS - 1; i++) begin
                  digits_in[i] = digits_ff[i+1];
               end
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      digits_ff   <= digits_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      neg_ff      <= neg_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_RESET;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            radix_ff <= csr_wdata;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_char_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

### rtl/core/sirt_checker.sv
// ----------------------------------------------------------------------------
// sirt_checker: port-level checks
// Watches the converter ports for character legality, sign placement,
// input throttling and output hold under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module sirt_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [7:0]  rsp_tdata,
   input wire        rsp_tlast
);
   import sirt_pkg::*;

   logic [6:0] ch;
   assign ch = rsp_tdata[6:0];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed under stall");

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[7] && ((ch == CHAR_MINUS) ||
         (ch >= CHAR_ZERO && ch <= CHAR_NINE) || (ch >= CHAR_A && ch <= CHAR_F)))
      else $error("illegal text character");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (ch == CHAR_MINUS) |-> !rsp_tlast)
      else $error("minus sign marked last");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after accepted word");

endmodule

bind signed_integer_to_radix_text sirt_checker u_sirt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
